// File: sv/cbhs_pkg.sv
// Shared package for the clamped bilinear height sampler.
// Widths, register indexes, read-select codes and the controller/datapath
// command and status structs. No dependencies.
`timescale 1ns / 1ps

package cbhs_pkg;

    localparam int TILE_SIDE_MAX = 256;
    localparam int MIN_SIDE      = 2;

    localparam int SIDE_W    = $clog2(TILE_SIDE_MAX + 1);
    localparam int COORD_W   = $clog2(TILE_SIDE_MAX);
    localparam int FRAC_W    = 16;
    localparam int HEIGHT_W  = 20;
    localparam int OUT_W     = 19;
    localparam int STORE_AW  = 16;
    localparam int STORE_DEPTH = 1 << STORE_AW;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    // clamped position: integer coordinate above 16 fraction bits
    localparam int POS_W = COORD_W + FRAC_W;

    localparam int HALF_TEXEL = 1 << (FRAC_W - 1);

    // blend arithmetic
    localparam int TB_W  = HEIGHT_W + FRAC_W + 2;  // row blend, 22.16 style
    localparam int LO_W  = TB_W / 2;               // low slice of row difference
    localparam int HI_W  = TB_W - LO_W;
    localparam int MA_W  = HEIGHT_W + 2;           // multiplier operand A
    localparam int MP_W  = MA_W + FRAC_W + 1;      // multiplier product
    localparam int SUM_W = TB_W + FRAC_W;          // full blend, 32 fraction bits

    localparam logic [CFG_W-1:0] CFG_SIDE_RESET = CFG_W'(256);

    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 1'b1;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef logic [1:0] cbhs_rdsel_t;

    localparam cbhs_rdsel_t RD_Y0X0 = 2'd0;
    localparam cbhs_rdsel_t RD_Y0X1 = 2'd1;
    localparam cbhs_rdsel_t RD_Y1X0 = 2'd2;
    localparam cbhs_rdsel_t RD_Y1X1 = 2'd3;

    typedef struct packed {
        logic        store_wr;   // write one height cell
        logic        take_item;  // latch position and flags of a sample request
        logic        base_en;    // row base addresses
        logic        rd_en;      // store read
        cbhs_rdsel_t rd_sel;
        logic        cap_c00;
        logic        mac_top;
        logic        cap_c10;
        logic        mac_bot;
        logic        diff_en;
        logic        mac_lo;
        logic        mac_hi;
        logic        out_load;   // load the result register
    } cbhs_cmd_t;

    typedef struct packed {
        logic sample_absent;     // tile missing or degenerate
    } cbhs_stat_t;

endpackage

// File: sv/cbhs_ctrl.sv
// Sequencing controller for the height sampler.
// Walks one sample request through address, read and blend steps; owns the
// handshakes. Depends on cbhs_pkg.
`timescale 1ns / 1ps

module cbhs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 command,
    input  logic                 out_stall,
    input  cbhs_pkg::cbhs_stat_t stat,
    output logic                 in_stall,
    output logic                 out_valid,
    output cbhs_pkg::cbhs_cmd_t  cmd
);
    import cbhs_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_BASE = 4'd1;
    localparam logic [3:0] ST_RD00 = 4'd2;
    localparam logic [3:0] ST_RD01 = 4'd3;
    localparam logic [3:0] ST_RD10 = 4'd4;
    localparam logic [3:0] ST_RD11 = 4'd5;
    localparam logic [3:0] ST_BOT  = 4'd6;
    localparam logic [3:0] ST_DIFF = 4'd7;
    localparam logic [3:0] ST_LO   = 4'd8;
    localparam logic [3:0] ST_HI   = 4'd9;
    localparam logic [3:0] ST_DONE = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == CMD_SAMPLE)
                    begin
                        cmd.take_item = 1'b1;
                        state_next    = stat.sample_absent ? ST_DONE : ST_BASE;
                    end
                    else
                    begin
                        cmd.store_wr = 1'b1;
                    end
                end
            end
            ST_BASE:
            begin
                cmd.base_en = 1'b1;
                state_next  = ST_RD00;
            end
            ST_RD00:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_Y0X0;
                state_next = ST_RD01;
            end
            ST_RD01:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_Y0X1;
                cmd.cap_c00 = 1'b1;
                state_next  = ST_RD10;
            end
            ST_RD10:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_Y1X0;
                cmd.mac_top = 1'b1;
                state_next  = ST_RD11;
            end
            ST_RD11:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_Y1X1;
                cmd.cap_c10 = 1'b1;
                state_next  = ST_BOT;
            end
            ST_BOT:
            begin
                cmd.mac_bot = 1'b1;
                state_next  = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.diff_en = 1'b1;
                state_next  = ST_LO;
            end
            ST_LO:
            begin
                cmd.mac_lo = 1'b1;
                state_next = ST_HI;
            end
            ST_HI:
            begin
                cmd.mac_hi = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sv/cbhs_datapath.sv
// Datapath of the height sampler: tile size registers, height store,
// position clamp, shared blend multiplier and result register.
// Depends on cbhs_pkg; steered by cbhs_ctrl.
`timescale 1ns / 1ps

module cbhs_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [cbhs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cbhs_pkg::CFG_W-1:0]            cfg_data,
    input  logic [cbhs_pkg::STORE_AW-1:0]         cell_index,
    input  logic signed [cbhs_pkg::HEIGHT_W-1:0]  height_value,
    input  logic [cbhs_pkg::FRAC_W-1:0]           frac_x,
    input  logic [cbhs_pkg::FRAC_W-1:0]           frac_y,
    input  logic                                  tile_present,
    input  cbhs_pkg::cbhs_cmd_t                   cmd,
    output cbhs_pkg::cbhs_stat_t                  stat,
    output logic [cbhs_pkg::OUT_W-1:0]            height_out,
    output logic                                  unresolved
);
    import cbhs_pkg::*;

    localparam int PW = FRAC_W + SIDE_W + 1;

    // frac * size - half texel, clamped to [0, (size-1) << 16]
    function automatic logic [POS_W-1:0] axis_pos(
        input logic [FRAC_W-1:0] frac,
        input logic [SIDE_W-1:0] size
    );
        logic [FRAC_W+SIDE_W-1:0] prod;
        logic signed [PW-1:0]     p;
        logic signed [PW-1:0]     hi;
        logic [POS_W-1:0]         r;
        prod = {{SIDE_W{1'b0}}, frac} * {{FRAC_W{1'b0}}, size};
        p    = $signed({1'b0, prod}) - $signed(PW'(HALF_TEXEL));
        hi   = $signed({1'b0, size - SIDE_W'(1), {FRAC_W{1'b0}}});
        if (p < 0)
        begin
            r = '0;
        end
        else if (p > hi)
        begin
            r = hi[POS_W-1:0];
        end
        else
        begin
            r = p[POS_W-1:0];
        end
        return r;
    endfunction

    logic [CFG_W-1:0]          tile_width_reg;
    logic [CFG_W-1:0]          tile_height_reg;
    logic [SIDE_W-1:0]         w_eff;
    logic [SIDE_W-1:0]         h_eff;

    logic [POS_W-1:0]          px;
    logic [POS_W-1:0]          py;
    logic [COORD_W-1:0]        px_int;
    logic [COORD_W-1:0]        py_int;

    logic [COORD_W-1:0]        x0_reg;
    logic [COORD_W-1:0]        x1_reg;
    logic [COORD_W-1:0]        y0_reg;
    logic [COORD_W-1:0]        y1_reg;
    logic [FRAC_W-1:0]         fx_reg;
    logic [FRAC_W-1:0]         fy_reg;
    logic                      unres_reg;

    logic [STORE_AW-1:0]       base0_reg;
    logic [STORE_AW-1:0]       base1_reg;
    logic [STORE_AW-1:0]       rd_addr;
    logic [STORE_AW-1:0]       mem_addr;

    logic [HEIGHT_W-1:0]       store_mem [0:STORE_DEPTH-1];
    logic [HEIGHT_W-1:0]       rdata_reg;
    logic signed [HEIGHT_W-1:0] rdata_s;

    logic signed [HEIGHT_W-1:0] c00_reg;
    logic signed [HEIGHT_W-1:0] c10_reg;
    logic signed [HEIGHT_W-1:0] c_ref;
    logic signed [HEIGHT_W:0]   dcell;

    logic signed [MA_W-1:0]    mul_a;
    logic [FRAC_W-1:0]         mul_b;
    logic signed [MP_W-1:0]    mul_p;

    logic signed [TB_W-1:0]    top_reg;
    logic signed [TB_W-1:0]    bot_reg;
    logic signed [TB_W-1:0]    diff_reg;
    logic signed [SUM_W-1:0]   acc_reg;
    logic signed [SUM_W-1:0]   rnd;

    logic [OUT_W-1:0]          height_out_reg;
    logic                      unres_out_reg;

    // sizes above the maximum are used as the maximum
    assign w_eff = (int'(tile_width_reg) > TILE_SIDE_MAX) ? SIDE_W'(TILE_SIDE_MAX)
                                                           : SIDE_W'(tile_width_reg);
    assign h_eff = (int'(tile_height_reg) > TILE_SIDE_MAX) ? SIDE_W'(TILE_SIDE_MAX)
                                                            : SIDE_W'(tile_height_reg);

    assign stat.sample_absent = (tile_present == 1'b0)
                             || (int'(tile_width_reg) < MIN_SIDE)
                             || (int'(tile_height_reg) < MIN_SIDE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_width_reg  <= CFG_SIDE_RESET;
            tile_height_reg <= CFG_SIDE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TILE_WIDTH:  tile_width_reg  <= cfg_data;
                REG_TILE_HEIGHT: tile_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // position clamp straight off the request
    assign px     = axis_pos(frac_x, w_eff);
    assign py     = axis_pos(frac_y, h_eff);
    assign px_int = px[POS_W-1:FRAC_W];
    assign py_int = py[POS_W-1:FRAC_W];

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            unres_reg <= stat.sample_absent;
            x0_reg    <= px_int;
            y0_reg    <= py_int;
            fx_reg    <= px[FRAC_W-1:0];
            fy_reg    <= py[FRAC_W-1:0];
            // second neighbour holds at the last column / row
            x1_reg    <= (SIDE_W'(px_int) == w_eff - SIDE_W'(1)) ? px_int
                                                                 : px_int + COORD_W'(1);
            y1_reg    <= (SIDE_W'(py_int) == h_eff - SIDE_W'(1)) ? py_int
                                                                 : py_int + COORD_W'(1);
        end
        if (cmd.base_en)
        begin
            base0_reg <= STORE_AW'(y0_reg) * STORE_AW'(w_eff);
            base1_reg <= STORE_AW'(y1_reg) * STORE_AW'(w_eff);
        end
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_Y0X0: rd_addr = base0_reg + STORE_AW'(x0_reg);
            RD_Y0X1: rd_addr = base0_reg + STORE_AW'(x1_reg);
            RD_Y1X0: rd_addr = base1_reg + STORE_AW'(x0_reg);
            RD_Y1X1: rd_addr = base1_reg + STORE_AW'(x1_reg);
            default: rd_addr = base0_reg + STORE_AW'(x0_reg);
        endcase
    end

    // single port: loads and sample reads never share a cycle
    assign mem_addr = cmd.store_wr ? cell_index : rd_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.store_wr)
        begin
            store_mem[mem_addr] <= height_value;
        end
        else if (cmd.rd_en)
        begin
            rdata_reg <= store_mem[mem_addr];
        end
    end

    assign rdata_s = $signed(rdata_reg);

    // shared multiplier: first along x with cell differences, then along y
    // with the row difference cut into a low and a high slice
    assign c_ref = cmd.mac_bot ? c10_reg : c00_reg;
    assign dcell = (HEIGHT_W+1)'(rdata_s) - (HEIGHT_W+1)'(c_ref);

    always_comb
    begin
        if (cmd.mac_lo)
        begin
            mul_a = MA_W'($signed({1'b0, diff_reg[LO_W-1:0]}));
        end
        else if (cmd.mac_hi)
        begin
            mul_a = MA_W'($signed(diff_reg[TB_W-1:LO_W]));
        end
        else
        begin
            mul_a = MA_W'(dcell);
        end
    end

    assign mul_b = (cmd.mac_lo || cmd.mac_hi) ? fy_reg : fx_reg;
    assign mul_p = mul_a * $signed({1'b0, mul_b});

    always_ff @(posedge clk)
    begin
        if (cmd.cap_c00)
        begin
            c00_reg <= rdata_s;
        end
        if (cmd.cap_c10)
        begin
            c10_reg <= rdata_s;
        end
        if (cmd.mac_top)
        begin
            top_reg <= (TB_W'(c00_reg) <<< FRAC_W) + TB_W'(mul_p);
        end
        if (cmd.mac_bot)
        begin
            bot_reg <= (TB_W'(c10_reg) <<< FRAC_W) + TB_W'(mul_p);
        end
        if (cmd.diff_en)
        begin
            diff_reg <= bot_reg - top_reg;
        end
        if (cmd.mac_lo)
        begin
            acc_reg <= (SUM_W'(top_reg) <<< FRAC_W) + SUM_W'(mul_p);
        end
        else if (cmd.mac_hi)
        begin
            acc_reg <= acc_reg + (SUM_W'(mul_p) <<< LO_W);
        end
    end

    // round half up, negative gives zero
    assign rnd = acc_reg + (SUM_W'(1) <<< (2*FRAC_W - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (unres_reg)
            begin
                height_out_reg <= '0;
                unres_out_reg  <= 1'b1;
            end
            else
            begin
                height_out_reg <= acc_reg[SUM_W-1] ? '0 : rnd[2*FRAC_W +: OUT_W];
                unres_out_reg  <= 1'b0;
            end
        end
    end

    assign height_out = height_out_reg;
    assign unresolved = unres_out_reg;

endmodule

// File: sv/clamped_bilinear_height_sampler_top.sv
// Clamped bilinear height sampler, top level. Uses cbhs_pkg, cbhs_ctrl, cbhs_datapath.
// Load request: written into the height store, no result. Sample request: no new request
// is taken until its result is loaded, the pace set by the single store port (four reads)
// and the one shared blend multiplier. Absent tile: the reads and blend are skipped and
// the result is loaded directly. A stalled result also holds off new requests.
// Reset (rst_n low, async): controller idle, no result pending, tile size 256 x 256;
// the height store is not cleared and holds nothing defined until loaded.
`timescale 1ns / 1ps

module clamped_bilinear_height_sampler_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [cbhs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cbhs_pkg::CFG_W-1:0]            cfg_data,
    // request channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  command,
    input  logic [cbhs_pkg::STORE_AW-1:0]         cell_index,
    input  logic signed [cbhs_pkg::HEIGHT_W-1:0]  height_value,
    input  logic [cbhs_pkg::FRAC_W-1:0]           frac_x,
    input  logic [cbhs_pkg::FRAC_W-1:0]           frac_y,
    input  logic                                  tile_present,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [cbhs_pkg::OUT_W-1:0]            height_out,
    output logic                                  unresolved
);
    import cbhs_pkg::*;

    // Flow of a sample request:
    //   accept  - position clamped from frac_x/frac_y and latched, with the
    //             neighbour coordinates and the 16-bit weights
    //   base    - row base addresses y0*w and y1*w (wrapped to 16 bits)
    //   reads   - four store reads, one per cycle, data registered
    //   blend   - top and bottom row blends as data arrive, then the row
    //             difference, then the vertical blend in two slices
    //   done    - rounding and zero clamp into the result register
    // The result register parts the two sides: a new request is taken while
    // a finished result still waits downstream.

    cbhs_cmd_t  cmd;
    cbhs_stat_t stat;

    cbhs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .command   (command),
        .out_stall (out_stall),
        .stat      (stat),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    cbhs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cell_index   (cell_index),
        .height_value (height_value),
        .frac_x       (frac_x),
        .frac_y       (frac_y),
        .tile_present (tile_present),
        .cmd          (cmd),
        .stat         (stat),
        .height_out   (height_out),
        .unresolved   (unresolved)
    );

`ifndef ASSERT_OFF
    // a new result never overwrites one still waiting
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("result register loaded while occupied");

    // unresolved results carry zero height
    a_unres_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && unresolved) |-> (height_out == '0))
        else $error("unresolved result with non-zero height");

    // valid only rises after a result load
    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("result valid without a load");

    // store reads happen only while requests are held off
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (in_stall && !cmd.store_wr))
        else $error("store read while requests are accepted");
`endif

endmodule

// File: sim/clamped_bilinear_height_sampler_top_tb.sv
// Self-checking testbench for clamped_bilinear_height_sampler_top.
// Holds its own bilinear height predictor and a small result scoreboard.
// Depends only on cbhs_pkg and the top level RTL.
`timescale 1ns / 1ps

module clamped_bilinear_height_sampler_top_tb;

    import cbhs_pkg::*;

    localparam int    NUM_PHASES      = 12;
    localparam int    ITEMS_PER_PHASE = 110;
    localparam int    SETTLE_CYCLES   = 24;
    localparam int    IDLE_MAX        = 19;
    localparam longint ONE_Q16        = longint'(1) << FRAC_W;

    localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = 20'sh7FFFF;
    localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = 20'sh80000;

    // one result as the block should present it
    typedef struct {
        logic [OUT_W-1:0] height;
        logic             unres;
    } sample_result_t;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the height store and tile size, predicts each
    // sample and matches results in order.
    // ------------------------------------------------------------------
    class height_scoreboard;
        logic signed [HEIGHT_W-1:0] heights [STORE_DEPTH];
        bit                         loaded  [STORE_DEPTH];
        logic [CFG_W-1:0]           width_reg;
        logic [CFG_W-1:0]           height_reg;
        sample_result_t             awaited_q [$];
        int                         errors;

        function new();
            width_reg  = CFG_SIDE_RESET;
            height_reg = CFG_SIDE_RESET;
            errors     = 0;
        endfunction

        function void write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_TILE_WIDTH)
                width_reg = val;
            else if (idx == REG_TILE_HEIGHT)
                height_reg = val;
        endfunction

        function int unsigned eff_size(logic [CFG_W-1:0] s);
            return (s > TILE_SIDE_MAX) ? TILE_SIDE_MAX : int'(s);
        endfunction

        // position along one axis, 16 fraction bits, half texel back, clamped
        function longint axis_q16(logic [FRAC_W-1:0] frac, int unsigned size);
            longint p;
            longint hi;
            p  = longint'(frac) * longint'(size) - HALF_TEXEL;
            hi = longint'(size - 1) << FRAC_W;
            if (p < 0)
                p = 0;
            if (p > hi)
                p = hi;
            return p;
        endfunction

        // store addresses of the four neighbours and the two weights;
        // returns 0 when the tile is degenerate
        function bit corner_cells(input logic [FRAC_W-1:0] fx, input logic [FRAC_W-1:0] fy,
                                  output logic [3:0][STORE_AW-1:0] cells,
                                  output longint wx, output longint wy);
            int unsigned w, h, x0, y0, x1, y1;
            longint px, py;
            cells = '0;
            wx    = 0;
            wy    = 0;
            w = eff_size(width_reg);
            h = eff_size(height_reg);
            if (w < MIN_SIDE || h < MIN_SIDE)
                return 1'b0;
            px = axis_q16(fx, w);
            py = axis_q16(fy, h);
            x0 = int'(px >> FRAC_W);
            y0 = int'(py >> FRAC_W);
            wx = px & (ONE_Q16 - 1);
            wy = py & (ONE_Q16 - 1);
            // second neighbour sticks to the last column / row
            x1 = (x0 + 1 < w) ? x0 + 1 : x0;
            y1 = (y0 + 1 < h) ? y0 + 1 : y0;
            cells[RD_Y0X0] = STORE_AW'(y0 * w + x0);
            cells[RD_Y0X1] = STORE_AW'(y0 * w + x1);
            cells[RD_Y1X0] = STORE_AW'(y1 * w + x0);
            cells[RD_Y1X1] = STORE_AW'(y1 * w + x1);
            return 1'b1;
        endfunction

        function void note_request(logic cmd, logic [STORE_AW-1:0] idx,
                                   logic signed [HEIGHT_W-1:0] hv,
                                   logic [FRAC_W-1:0] fx, logic [FRAC_W-1:0] fy,
                                   logic present);
            logic [3:0][STORE_AW-1:0] c;
            longint         wx, wy, top, bot, sum;
            sample_result_t r;
            if (cmd == CMD_LOAD) begin
                heights[idx] = hv;
                loaded[idx]  = 1'b1;
                return;
            end
            r.height = '0;
            r.unres  = 1'b1;
            if (present && corner_cells(fx, fy, c, wx, wy)) begin
                top = longint'(heights[c[RD_Y0X0]]) * (ONE_Q16 - wx)
                    + longint'(heights[c[RD_Y0X1]]) * wx;
                bot = longint'(heights[c[RD_Y1X0]]) * (ONE_Q16 - wx)
                    + longint'(heights[c[RD_Y1X1]]) * wx;
                sum = top * (ONE_Q16 - wy) + bot * wy;
                r.unres = 1'b0;
                // below ground reads zero; otherwise round half up off 32 bits
                if (sum >= 0)
                    r.height = OUT_W'((sum + (longint'(1) << 31)) >>> 32);
            end
            awaited_q = {awaited_q, r};
        endfunction

        function void check_result(logic [OUT_W-1:0] hout, logic unres);
            sample_result_t e;
            if (awaited_q.size() == 0) begin
                $display("%0t: result with none awaited: height_out %0d unresolved %0b",
                         $time, hout, unres);
                errors++;
                return;
            end
            e = awaited_q.pop_front();
            if (hout !== e.height) begin
                $display("%0t: height_out expected %0d actual %0d", $time, e.height, hout);
                errors++;
            end
            if (unres !== e.unres) begin
                $display("%0t: unresolved expected %0b actual %0b", $time, e.unres, unres);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------
    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]            cfg_data;
    logic                        in_valid;
    logic                        in_stall;
    logic                        command;
    logic [STORE_AW-1:0]         cell_index;
    logic signed [HEIGHT_W-1:0]  height_value;
    logic [FRAC_W-1:0]           frac_x;
    logic [FRAC_W-1:0]           frac_y;
    logic                        tile_present;
    logic                        out_valid;
    logic                        out_stall;
    logic [OUT_W-1:0]            height_out;
    logic                        unresolved;

    clamped_bilinear_height_sampler_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .cell_index   (cell_index),
        .height_value (height_value),
        .frac_x       (frac_x),
        .frac_y       (frac_y),
        .tile_present (tile_present),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .height_out   (height_out),
        .unresolved   (unresolved)
    );

    height_scoreboard sb;

    // idle controls, changed per phase; quiet_tail switches all idling off
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    bit          quiet_tail;
    int unsigned requests_taken;

    logic [CFG_W-1:0] phase_w [NUM_PHASES];
    logic [CFG_W-1:0] phase_h [NUM_PHASES];

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Result side: stall in random bursts with calm runs between.
    // Sampled on the falling edge, so the check sees exactly what the
    // next rising edge will take.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned rx_hold;
        rx_hold   = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (quiet_tail)
            begin
                out_stall <= 1'b0;
                rx_hold = 0;
            end
            else if (rx_hold > 0)
                rx_hold--;
            else if ($urandom_range(1, 100) <= rx_idle_pct)
            begin
                out_stall <= 1'b1;
                rx_hold = $urandom_range(1, IDLE_MAX) - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                rx_hold = $urandom_range(0, 15);
            end
        end
    end

    always @(negedge clk)
    begin
        if (out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_result(height_out, unresolved);
    end

    // ------------------------------------------------------------------
    // Request side helpers
    // ------------------------------------------------------------------
    function automatic logic signed [HEIGHT_W-1:0] rand_height();
        case ($urandom_range(0, 9))
            0:       return HEIGHT_MAX;
            1:       return HEIGHT_MIN;
            default: return HEIGHT_W'($urandom);
        endcase
    endfunction

    // positions hug the tile edges now and then
    function automatic logic [FRAC_W-1:0] rand_frac();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return FRAC_W'($urandom);
        endcase
    endfunction

    // Present one request, hold it until taken, then maybe idle a burst.
    // in_valid stays high when the next request follows at once.
    task automatic send_request(input logic cmd, input logic [STORE_AW-1:0] idx,
                                input logic signed [HEIGHT_W-1:0] hv,
                                input logic [FRAC_W-1:0] fx, input logic [FRAC_W-1:0] fy,
                                input logic present);
        bit took;
        in_valid     <= 1'b1;
        command      <= cmd;
        cell_index   <= idx;
        height_value <= hv;
        frac_x       <= fx;
        frac_y       <= fy;
        tile_present <= present;
        do
        begin
            @(negedge clk);
            took = (in_stall === 1'b0);
            @(posedge clk);
        end
        while (!took);
        sb.note_request(cmd, idx, hv, fx, fy, present);
        requests_taken++;
        if (!quiet_tail && $urandom_range(1, 100) <= tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, IDLE_MAX)) @(posedge clk);
        end
    endtask

    task automatic load_cell(input logic [STORE_AW-1:0] idx,
                             input logic signed [HEIGHT_W-1:0] hv);
        send_request(CMD_LOAD, idx, hv, FRAC_W'($urandom), FRAC_W'($urandom), 1'($urandom));
    endtask

    // A present sample on a usable tile is only sent once all four neighbours
    // hold a written height; missing ones are loaded first with random heights.
    task automatic sample_at(input logic [FRAC_W-1:0] fx, input logic [FRAC_W-1:0] fy,
                             input logic present);
        logic [3:0][STORE_AW-1:0] corners;
        longint wx, wy;
        if (present && sb.corner_cells(fx, fy, corners, wx, wy))
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (!sb.loaded[corners[k]])
                    load_cell(corners[k], rand_height());
            end
        end
        send_request(CMD_SAMPLE, STORE_AW'($urandom), rand_height(), fx, fy, present);
    endtask

    // Stop sending and wait until every awaited result is back, then let
    // any trailing load finish before touching the registers.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_config(idx, val);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned phase_start;
        int unsigned span;
        int unsigned pick;
        bit          mid_drain_done;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_TILE_WIDTH;
        cfg_data       = '0;
        in_valid       = 1'b0;
        command        = CMD_LOAD;
        cell_index     = '0;
        height_value   = '0;
        frac_x         = '0;
        frac_y         = '0;
        tile_present   = 1'b0;
        tx_idle_pct    = 20;
        rx_idle_pct    = 20;
        quiet_tail     = 1'b0;
        requests_taken = 0;
        mid_drain_done = 1'b0;

        // tile sizes per phase: smallest, odd, extremes, degenerate, oversized
        phase_w = '{9'd2, 9'd3,  9'd256, 9'd2,   9'd0,   9'd256,
                    9'd511, 9'd16, 9'd100, 9'd1, 9'd5, 9'd256};
        phase_h = '{9'd2, 9'd17, 9'd2,   9'd256, 9'd256, 9'd1,
                    9'd300, 9'd16, 9'd7,   9'd9, 9'd200, 9'd256};

        sb = new();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part, reset tile size 256 x 256 ---
        // full-scale heights at the top left corner
        load_cell(16'd0,   HEIGHT_MAX);
        load_cell(16'd1,   HEIGHT_MIN);
        load_cell(16'd256, HEIGHT_MAX);
        load_cell(16'd257, HEIGHT_MIN);
        sample_at(16'h0000, 16'h0000, 1'b1);   // clamps below zero position: top max
        sample_at(16'h0100, 16'h0000, 1'b1);   // half way max/min: slightly negative, floors at 0
        // exact tie between 1 and 2 rounds upward
        load_cell(16'd2,   20'sd1);
        load_cell(16'd3,   20'sd2);
        load_cell(16'd258, 20'sd1);
        load_cell(16'd259, 20'sd2);
        sample_at(16'h0300, 16'h0000, 1'b1);
        // far corner: both second neighbours clamp onto the last cell
        load_cell(16'hFFFF, 20'sd3);
        sample_at(16'hFFFF, 16'hFFFF, 1'b1);
        load_cell(16'hFFFF, -20'sd5);
        sample_at(16'hFFFF, 16'hFFFF, 1'b1);
        sample_at(16'hFFFF, 16'h0000, 1'b0);   // tile absent
        sample_at(16'h8000, 16'h8000, 1'b1);   // centre, loads its own neighbours

        // --- random phases ---
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            write_reg(REG_TILE_WIDTH,  phase_w[ph]);
            write_reg(REG_TILE_HEIGHT, phase_h[ph]);
            quiet_tail  = (ph == NUM_PHASES - 1);
            tx_idle_pct = (ph % 4) * 15;
            rx_idle_pct = ((ph + 2) % 4) * 15;
            span = sb.eff_size(phase_w[ph]) * sb.eff_size(phase_h[ph]);
            if (span == 0)
                span = 1;
            phase_start = requests_taken;
            while (requests_taken - phase_start < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 25)
                    load_cell($urandom_range(0, 1) ? STORE_AW'($urandom_range(0, span - 1))
                                                   : STORE_AW'($urandom),
                              rand_height());
                else
                    sample_at(rand_frac(), rand_frac(), pick >= 33);
                // once mid-run, let the pipeline run dry before carrying on
                if (ph == 2 && !mid_drain_done && requests_taken - phase_start >= 60)
                begin
                    drain();
                    mid_drain_done = 1'b1;
                end
            end
        end

        drain();
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
sv/cbhs_pkg.sv
sv/cbhs_ctrl.sv
sv/cbhs_datapath.sv
sv/clamped_bilinear_height_sampler_top.sv
sim/clamped_bilinear_height_sampler_top_tb.sv
